[rtl/core/codeword_delta_pixel_toggler_assert.svh]
// Assertion macros shared by the codeword delta pixel toggler RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef CODEWORD_DELTA_PIXEL_TOGGLER_ASSERT_SVH
`define CODEWORD_DELTA_PIXEL_TOGGLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CDPT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cdpt assertion failed");
`define CDPT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cdpt assertion failed");
`else
`define CDPT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CDPT_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/cdpt_pkg.sv]
// Package for the codeword delta pixel toggler: widths, codes and FSM type.
// No dependencies.
package cdpt_pkg;
	localparam int MAX_CODEWORDS = 4096;
	localparam int OFFSET_BITS = 16;
	localparam int MASK_BITS = 8;
	localparam int WORD_BITS = 8;
	localparam int STRIDE_BITS = 8;
	localparam int INDEX_BITS = 15;
	localparam int BIT_SEL_BITS = 3;
	localparam int CW_BITS = INDEX_BITS - BIT_SEL_BITS;
	localparam int TABLE_DEPTH = 1 << INDEX_BITS;
	localparam int TABLE_WIDTH = OFFSET_BITS + MASK_BITS;
	localparam int PREV_AW_RAW = (MAX_CODEWORDS > 1) ? $clog2(MAX_CODEWORDS) : 1;
	localparam int PREV_AW = (PREV_AW_RAW > CW_BITS) ? CW_BITS : PREV_AW_RAW;
	localparam int PREV_DEPTH = (MAX_CODEWORDS > (1 << PREV_AW)) ? (1 << PREV_AW) : MAX_CODEWORDS;
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam int ROW_STRIDE_RESET = 80;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_PRIME  = 2'd1,
		ACT_UPDATE = 2'd2
	} action_t;

	typedef enum logic {
		REG_DOUBLE_ROWS = 1'b0,
		REG_ROW_STRIDE  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREV,
		S_EMIT,
		S_EMIT2
	} state_t;
endpackage

[rtl/core/cdpt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cdpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/core/codeword_delta_pixel_toggler.sv]
// Top level of the codeword delta pixel toggler: APB registers, command FSM, toggle output.
// Depends on cdpt_pkg, cdpt_ram and codeword_delta_pixel_toggler_assert.svh.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-------------------------------------------
//  command  | start & !busy                    | action, index, entry_offset, entry_mask, codeword
//  toggle   | toggle_valid (one-cycle strobe)  | byte_offset, toggle_mask, last
//  config   | psel & penable & pwrite & pready | paddr, pwdata (prdata on reads)
//
// Load and prime beats leave busy low.
// An update holds busy while the previous word is read and its toggles leave, one per changed bit,
// or two per changed bit with double_rows; after the RAM read, one toggle leaves per cycle.
// Toggles appear in the cycle after they are formed, through the output register.
// Memories are undefined after reset; no clearing pass. The receiver cannot stall.
module codeword_delta_pixel_toggler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cdpt_pkg::PADDR_BITS-1:0]      paddr,
	input  logic [cdpt_pkg::PDATA_BITS-1:0]      pwdata,
	output logic [cdpt_pkg::PDATA_BITS-1:0]      prdata,
	output logic                                 pready,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           action,
	input  logic [cdpt_pkg::INDEX_BITS-1:0]      index,
	input  logic [cdpt_pkg::OFFSET_BITS-1:0]     entry_offset,
	input  logic [cdpt_pkg::MASK_BITS-1:0]       entry_mask,
	input  logic [cdpt_pkg::WORD_BITS-1:0]       codeword,
	output logic                                 toggle_valid,
	output logic [cdpt_pkg::OFFSET_BITS-1:0]     byte_offset,
	output logic [cdpt_pkg::MASK_BITS-1:0]       toggle_mask,
	output logic                                 last
);
	`include "codeword_delta_pixel_toggler_assert.svh"

	cdpt_pkg::state_t state_q, state_d;

	logic                                 double_rows_q;
	logic [cdpt_pkg::STRIDE_BITS-1:0]     row_stride_q;
	logic [cdpt_pkg::CW_BITS-1:0]         cw_q;
	logic [cdpt_pkg::WORD_BITS-1:0]       word_q;
	logic [cdpt_pkg::WORD_BITS-1:0]       remaining_q;
	logic [cdpt_pkg::OFFSET_BITS-1:0]     off2_q;
	logic [cdpt_pkg::MASK_BITS-1:0]       mask2_q;
	logic                                 toggle_valid_q;
	logic [cdpt_pkg::OFFSET_BITS-1:0]     byte_offset_q;
	logic [cdpt_pkg::MASK_BITS-1:0]       toggle_mask_q;
	logic                                 last_q;

	logic                                 accept;
	logic                                 cfg_wr;
	cdpt_pkg::reg_idx_t                   reg_sel;
	logic [cdpt_pkg::CW_BITS-1:0]         cw_in;
	logic                                 cw_ok;

	logic                                 prev_we, prev_re;
	logic [cdpt_pkg::PREV_AW-1:0]         prev_waddr;
	logic [cdpt_pkg::WORD_BITS-1:0]       prev_wdata;
	logic [cdpt_pkg::WORD_BITS-1:0]       prev_rdata;
	logic                                 tbl_we, tbl_re;
	logic [cdpt_pkg::INDEX_BITS-1:0]      tbl_raddr;
	logic [cdpt_pkg::TABLE_WIDTH-1:0]     tbl_rdata;
	logic [cdpt_pkg::OFFSET_BITS-1:0]     tbl_off;
	logic [cdpt_pkg::MASK_BITS-1:0]       tbl_mask;

	logic [cdpt_pkg::WORD_BITS-1:0]       changed;
	logic [cdpt_pkg::WORD_BITS-1:0]       pick_src;
	logic [cdpt_pkg::WORD_BITS-1:0]       pick_rest;
	logic [cdpt_pkg::BIT_SEL_BITS-1:0]    pick_k;

	logic                                 load_rest, load_second;
	logic                                 emit, emit_last;
	logic [cdpt_pkg::OFFSET_BITS-1:0]     emit_off;
	logic [cdpt_pkg::MASK_BITS-1:0]       emit_mask;

	assign busy    = (state_q != cdpt_pkg::S_IDLE);
	assign accept  = start & ~busy;
	assign cw_in   = index[cdpt_pkg::CW_BITS-1:0];
	assign cw_ok   = (32'(cw_in) < 32'(cdpt_pkg::MAX_CODEWORDS));
	assign changed = word_q ^ prev_rdata;
	assign tbl_off  = tbl_rdata[cdpt_pkg::TABLE_WIDTH-1 -: cdpt_pkg::OFFSET_BITS];
	assign tbl_mask = tbl_rdata[cdpt_pkg::MASK_BITS-1:0];
	assign tbl_raddr = {cw_q, pick_k};

	// APB
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_sel = cdpt_pkg::reg_idx_t'(paddr[2]);

	always_comb begin
		case (reg_sel)
			cdpt_pkg::REG_DOUBLE_ROWS: prdata = cdpt_pkg::PDATA_BITS'(double_rows_q);
			cdpt_pkg::REG_ROW_STRIDE:  prdata = cdpt_pkg::PDATA_BITS'(row_stride_q);
			default:                   prdata = '0;
		endcase
	end

	// highest remaining changed bit first
	always_comb begin
		pick_src  = (state_q == cdpt_pkg::S_PREV) ? changed : remaining_q;
		pick_k    = '0;
		pick_rest = pick_src;
		for (int i = 0; i < cdpt_pkg::WORD_BITS; i++) begin
			if (pick_src[i]) begin
				pick_k    = cdpt_pkg::BIT_SEL_BITS'(cdpt_pkg::WORD_BITS - 1 - i);
				pick_rest = pick_src & ~(cdpt_pkg::WORD_BITS'(1) << i);
			end
		end
	end

	assign prev_waddr = (state_q == cdpt_pkg::S_IDLE) ? cw_in[cdpt_pkg::PREV_AW-1:0]
		: cw_q[cdpt_pkg::PREV_AW-1:0];
	assign prev_wdata = (state_q == cdpt_pkg::S_IDLE) ? codeword : word_q;

	cdpt_ram #(
		.WIDTH(cdpt_pkg::WORD_BITS),
		.DEPTH(cdpt_pkg::PREV_DEPTH)
	) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.re    (prev_re),
		.raddr (cw_in[cdpt_pkg::PREV_AW-1:0]),
		.rdata (prev_rdata)
	);

	cdpt_ram #(
		.WIDTH(cdpt_pkg::TABLE_WIDTH),
		.DEPTH(cdpt_pkg::TABLE_DEPTH)
	) u_table_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (index),
		.wdata ({entry_offset, entry_mask}),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cdpt_pkg::S_IDLE: begin
				if (accept && action == cdpt_pkg::ACT_UPDATE && cw_ok) begin
					state_d = cdpt_pkg::S_PREV;
				end
			end
			cdpt_pkg::S_PREV: begin
				state_d = (changed != '0) ? cdpt_pkg::S_EMIT : cdpt_pkg::S_IDLE;
			end
			cdpt_pkg::S_EMIT: begin
				if (double_rows_q) begin
					state_d = cdpt_pkg::S_EMIT2;
				end else if (remaining_q == '0) begin
					state_d = cdpt_pkg::S_IDLE;
				end
			end
			cdpt_pkg::S_EMIT2: begin
				state_d = (remaining_q != '0) ? cdpt_pkg::S_EMIT : cdpt_pkg::S_IDLE;
			end
			default: state_d = cdpt_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		prev_we     = 1'b0;
		prev_re     = 1'b0;
		tbl_we      = 1'b0;
		tbl_re      = 1'b0;
		load_rest   = 1'b0;
		load_second = 1'b0;
		emit        = 1'b0;
		emit_last   = 1'b0;
		emit_off    = tbl_off;
		emit_mask   = tbl_mask;
		case (state_q)
			cdpt_pkg::S_IDLE: begin
				if (accept) begin
					case (action)
						cdpt_pkg::ACT_LOAD:   tbl_we  = 1'b1;
						cdpt_pkg::ACT_PRIME:  prev_we = cw_ok;
						cdpt_pkg::ACT_UPDATE: prev_re = cw_ok;
						default: ;
					endcase
				end
			end
			cdpt_pkg::S_PREV: begin
				prev_we = 1'b1;
				if (changed != '0) begin
					tbl_re    = 1'b1;
					load_rest = 1'b1;
				end
			end
			cdpt_pkg::S_EMIT: begin
				emit = 1'b1;
				if (double_rows_q) begin
					load_second = 1'b1;
				end else begin
					emit_last = (remaining_q == '0);
					tbl_re    = (remaining_q != '0);
					load_rest = (remaining_q != '0);
				end
			end
			cdpt_pkg::S_EMIT2: begin
				emit      = 1'b1;
				emit_off  = off2_q;
				emit_mask = mask2_q;
				emit_last = (remaining_q == '0);
				tbl_re    = (remaining_q != '0);
				load_rest = (remaining_q != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= cdpt_pkg::S_IDLE;
			double_rows_q  <= 1'b0;
			row_stride_q   <= cdpt_pkg::STRIDE_BITS'(cdpt_pkg::ROW_STRIDE_RESET);
			remaining_q    <= '0;
			toggle_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			toggle_valid_q <= emit;
			if (load_rest) begin
				remaining_q <= pick_rest;
			end
			if (cfg_wr) begin
				case (reg_sel)
					cdpt_pkg::REG_DOUBLE_ROWS: double_rows_q <= pwdata[0];
					cdpt_pkg::REG_ROW_STRIDE:  row_stride_q  <= pwdata[cdpt_pkg::STRIDE_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cw_q   <= cw_in;
			word_q <= codeword;
		end
		if (load_second) begin
			off2_q  <= tbl_off + cdpt_pkg::OFFSET_BITS'(row_stride_q);
			mask2_q <= tbl_mask;
		end
		byte_offset_q <= emit_off;
		toggle_mask_q <= emit_mask;
		last_q        <= emit_last;
	end

	assign toggle_valid = toggle_valid_q;
	assign byte_offset  = byte_offset_q;
	assign toggle_mask  = toggle_mask_q;
	assign last         = last_q;

	`CDPT_ASSERT_NXT(a_gap_after_last, clk, arst_n, toggle_valid && last, !toggle_valid)
	`CDPT_ASSERT_IMP(a_more_while_busy, clk, arst_n, toggle_valid && !last, busy)
	`CDPT_ASSERT_IMP(a_prev_port_excl, clk, arst_n, prev_re, !prev_we)
	`CDPT_ASSERT_IMP(a_second_needs_dbl, clk, arst_n, state_q == cdpt_pkg::S_EMIT2, double_rows_q)
endmodule
